// ----- sv/text_console_writer_defines.svh -----
// ----------------------------------------------------------------------------
// Text console writer - assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during rst.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Invariant that must hold at every edge out of reset.
`define TCW_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer - package
// Shared types and fixed codes of the console engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_data;
  } rsp_t;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'd18;

endpackage

// ----- sv/tcw_screen_ram.sv -----
// ----------------------------------------------------------------------------
// Text console writer - screen memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/tcw_engine.sv -----
// ----------------------------------------------------------------------------
// Text console writer - command engine
// Request sequencer, cursor and screen sweeps (scroll copy, fill, clear).
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module tcw_engine
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  input  logic [7:0]  attr,
  input  logic        slot_free,
  output logic        res_load,
  output rsp_t        res
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(COLS);
  localparam int YW    = $clog2(ROWS);
  localparam int IW    = ((AW > 11) ? AW : 11) + 1;

  state_t        state, state_next;
  logic [XW-1:0] x, x_next;
  logic [YW-1:0] y, y_next;
  logic [AW-1:0] base, base_next;
  logic [7:0]    ch;
  logic          rd_ok;
  logic [AW-1:0] sweep;
  logic          cp_pend;
  logic [AW-1:0] cp_dst;

  logic          fire;
  logic          is_nl;
  logic          wrap;
  logic          scroll_req;
  logic          sweep_last;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmd_stall  = (state != ST_IDLE);
  assign fire       = cmd_valid && !cmd_stall;
  assign is_nl      = ch inside {CHAR_LF, CHAR_CR};
  assign wrap       = is_nl || (x == XW'(COLS - 1));
  assign scroll_req = wrap && (y == YW'(ROWS - 1));
  assign sweep_last = (sweep == AW'(CELLS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          case (command)
            CMD_PUT:   state_next = ST_PUT;
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        if (scroll_req) begin
          state_next = ST_COPY;
        end else if (slot_free) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (sweep_last) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!cp_pend && sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR: begin
        if (sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // cursor update
  always_comb begin
    x_next    = x;
    y_next    = y;
    base_next = base;
    if (state == ST_PUT) begin
      if (wrap) begin
        x_next = '0;
        if (y != YW'(ROWS - 1)) begin
          y_next    = YW'(y + 1'b1);
          base_next = AW'(base + AW'(COLS));
        end
      end else begin
        x_next = XW'(x + 1'b1);
      end
    end else if (state == ST_CLEAR && sweep_last) begin
      x_next    = '0;
      y_next    = '0;
      base_next = '0;
    end
  end

  // memory ports and result
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sweep;
    wr_en   = 1'b0;
    wr_addr = sweep;
    wr_data = {attr, BLANK_CHAR};
    if (fire && command == CMD_READ) begin
      rd_en   = 1'b1;
      rd_addr = AW'(cell_index);
    end else if (state == ST_COPY) begin
      rd_en = 1'b1;
    end
    if (cp_pend) begin
      wr_en   = 1'b1;
      wr_addr = cp_dst;
      wr_data = rd_data;
    end else if (state == ST_PUT && !is_nl) begin
      wr_en   = 1'b1;
      wr_addr = AW'(base + AW'(x));
      wr_data = {attr, ch};
    end else if (state == ST_FILL || state == ST_CLEAR) begin
      wr_en = 1'b1;
    end

    res_load = slot_free && ((state == ST_PUT && !scroll_req) ||
                             state == ST_READ || state == ST_DONE);
    res.cursor_col = 7'(x_next);
    res.cursor_row = 5'(y_next);
    res.cell_data  = (state == ST_READ && rd_ok) ? rd_data : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      x       <= '0;
      y       <= '0;
      base    <= '0;
      cp_pend <= 1'b0;
    end else begin
      state   <= state_next;
      x       <= x_next;
      y       <= y_next;
      base    <= base_next;
      cp_pend <= (state == ST_COPY);
    end
  end

  always_ff @(posedge clk) begin
    cp_dst <= AW'(sweep - AW'(COLS));
    if (fire) begin
      ch    <= char_code;
      rd_ok <= (IW'(cell_index) < IW'(CELLS));
      sweep <= '0;
    end else if (state == ST_PUT) begin
      sweep <= AW'(COLS);
    end else if (state == ST_COPY) begin
      sweep <= sweep_last ? AW'(CELLS - COLS) : AW'(sweep + 1'b1);
    end else if (state == ST_CLEAR || (state == ST_FILL && !cp_pend)) begin
      sweep <= AW'(sweep + 1'b1);
    end
  end

  `TCW_ASSERT(a_col_range, x <= XW'(COLS - 1), "cursor column out of range")
  `TCW_ASSERT(a_row_range, y <= YW'(ROWS - 1), "cursor row out of range")
  `TCW_ASSERT(a_row_base, base == AW'(y * COLS), "row base out of step with cursor row")
  `TCW_ASSERT_IMPL(a_load_free, res_load, slot_free, "result loaded into a full slot")
  `TCW_ASSERT_IMPL(a_no_overlap, wr_en && rd_en, wr_addr != rd_addr, "read and write collide")

endmodule

// ----- sv/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// Text console writer - top level
// Text-mode console: screen memory of attribute/character cells and cursor.
// ----------------------------------------------------------------------------
// A put, read or unused request is handled in an engine state (ST_PUT,
// ST_READ or ST_DONE), from which its result is loaded into the output
// register; the next request is taken only once the engine is back in idle.
// The output register may wait on rsp_stall while the following request
// proceeds; that request then holds until the register frees. A newline on
// the bottom row (typed or by column wrap) scrolls the screen through the
// single write port, and a clear writes every cell once. The screen memory
// is not cleared after reset; issue a clear before reading cells that
// were never written.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  attribute,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [15:0] cell_data
);

  logic [7:0] attr;
  logic       slot_free;
  logic       res_load;
  rsp_t       res;
  rsp_t       rsp;

  assign cfg_ready = 1'b1;
  assign slot_free = !rsp_valid || !rsp_stall;

  tcw_engine #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .char_code  (char_code),
    .cell_index (cell_index),
    .attr       (attr),
    .slot_free  (slot_free),
    .res_load   (res_load),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attr      <= ATTR_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr <= attribute;
      end
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

  assign cursor_col = rsp.cursor_col;
  assign cursor_row = rsp.cursor_row;
  assign cell_data  = rsp.cell_data;

endmodule
